// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// expression never true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- hdl/kcws_pkg.sv -----
// Package: constants and codes of the Kronecker chain statistics block.
package kcws_pkg;
	localparam int MAX_DIM_DEF        = 64;
	localparam int MAX_FACTOR_DIM_DEF = 16;

	localparam int MODE_W  = 2;
	localparam int DIM_W   = 7;
	localparam int VALUE_W = 16;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 32;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam mode_t MODE_BEGIN  = 2'd0;
	localparam mode_t MODE_ELEM   = 2'd1;
	localparam mode_t MODE_FACTOR = 2'd2;
	localparam mode_t MODE_REPORT = 2'd3;

	localparam kind_t STAT_MAX_ELEM = 3'd0;
	localparam kind_t STAT_MIN_ELEM = 3'd1;
	localparam kind_t STAT_MAX_ROW  = 3'd2;
	localparam kind_t STAT_MIN_ROW  = 3'd3;
	localparam kind_t STAT_MAX_COL  = 3'd4;
	localparam kind_t STAT_MIN_COL  = 3'd5;

	localparam logic signed [STAT_W-1:0] EMPTY_BOUND = 32'sd2000000000;
endpackage

// ----- hdl/kcws_ram.sv -----
// Generic simple dual-port RAM with registered read.
module kcws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/kronecker_chain_with_stats_core.sv -----
// Top level: Kronecker product chain over a banked matrix store, with statistics report.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | mode, rows, cols, value
//  out     | out | out_valid/out_ready| stat_kind, stat_value, size_error, last
//
// Begin and element beats are taken while the block is idle. The element that completes a
// factor starts a product walk (one factor entry per cycle through the multiplier).
// A report walks the held matrix row by row, then walks the column sums, then gives
// six output beats. in_ready is low while a walk or report runs.
// Reset clears all control state; matrix memories are not cleared.
`include "assert_macros.svh"
module kronecker_chain_with_stats_core
	import kcws_pkg::*;
#(
	parameter int MAX_DIM        = MAX_DIM_DEF,
	parameter int MAX_FACTOR_DIM = MAX_FACTOR_DIM_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [MODE_W-1:0]        mode,
	input  logic [DIM_W-1:0]         rows,
	input  logic [DIM_W-1:0]         cols,
	input  logic signed [VALUE_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [KIND_W-1:0]        stat_kind,
	output logic signed [STAT_W-1:0] stat_value,
	output logic                     size_error,
	output logic                     last
);
	localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int FW  = (MAX_FACTOR_DIM > 1) ? $clog2(MAX_FACTOR_DIM) : 1;
	localparam int CW  = $clog2(MAX_DIM + 1);
	localparam int FCW = $clog2(MAX_FACTOR_DIM + 1);
	localparam int HA  = 2 * DW;
	localparam int FA  = 2 * FW;
	localparam int PW  = CW + DIM_W;
	localparam int NW  = CW + FCW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_APPLY = 3'd1;
	localparam logic [2:0] ST_ROWS  = 3'd2;
	localparam logic [2:0] ST_COLS  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]       state_q;
	logic             cur_q;
	logic [CW-1:0]    held_rows_q, held_cols_q;
	logic [FCW-1:0]   fac_rows_q, fac_cols_q;
	logic             loading_q, err_q, full_q;
	logic [DW-1:0]    lr_q, lc_q;
	logic [FW-1:0]    fr_q, fc_q;
	logic [DW-1:0]    wi_q, wj_q, rbase_q, cbase_q;
	logic [FW-1:0]    wk_q, wl_q;
	logic             issue_q;
	logic             v_s1, fst_s1, i0_s1, j0_s1, rend_s1;
	logic [HA-1:0]    dst_s1;
	logic [DW-1:0]    cj_s1;
	logic             v_s2;
	logic [HA-1:0]    dst_s2;
	logic [STAT_W-1:0] prod_s2;
	logic signed [STAT_W-1:0] emax_q, emin_q, rmax_q, rmin_q, cmax_q, cmin_q, rsum_q;
	logic             fwd_v_q;
	logic [DW-1:0]    fwd_a_q;
	logic [STAT_W-1:0] fwd_d_q;
	logic [2:0]       kcnt_q;

	logic             acc;
	logic             load_we, fac_we;
	logic             lc_last, lr_last, fc_last, fr_last;
	logic             wi_last, wj_last, wk_last, wl_last;
	logic             rows_ok0, rows_ok2;
	logic [PW-1:0]    prow, pcol;
	logic [NW-1:0]    nrows, ncols;
	logic [STAT_W-1:0] rd0, rd1, held_rd, col_rd;
	logic [VALUE_W-1:0] fac_rd;
	logic             we0, we1;
	logic [HA-1:0]    wa0, wa1;
	logic [STAT_W-1:0] wd0, wd1, load_data;
	logic signed [47:0] prod_full;
	logic signed [STAT_W-1:0] x, rs, cs, prev_col;
	logic             col_we;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	assign lc_last = ((DW+1)'(lc_q) + (DW+1)'(1)) == (DW+1)'(held_cols_q);
	assign lr_last = ((DW+1)'(lr_q) + (DW+1)'(1)) == (DW+1)'(held_rows_q);
	assign fc_last = ((FW+1)'(fc_q) + (FW+1)'(1)) == (FW+1)'(fac_cols_q);
	assign fr_last = ((FW+1)'(fr_q) + (FW+1)'(1)) == (FW+1)'(fac_rows_q);
	assign wi_last = ((DW+1)'(wi_q) + (DW+1)'(1)) == (DW+1)'(held_rows_q);
	assign wj_last = ((DW+1)'(wj_q) + (DW+1)'(1)) == (DW+1)'(held_cols_q);
	assign wk_last = ((FW+1)'(wk_q) + (FW+1)'(1)) == (FW+1)'(fac_rows_q);
	assign wl_last = ((FW+1)'(wl_q) + (FW+1)'(1)) == (FW+1)'(fac_cols_q);

	assign rows_ok0 = (rows != '0) && (cols != '0) && (32'(rows) <= 32'(MAX_DIM))
		&& (32'(cols) <= 32'(MAX_DIM));
	assign prow = PW'(held_rows_q) * PW'(rows);
	assign pcol = PW'(held_cols_q) * PW'(cols);
	assign rows_ok2 = (rows != '0) && (cols != '0) && (32'(rows) <= 32'(MAX_FACTOR_DIM))
		&& (32'(cols) <= 32'(MAX_FACTOR_DIM)) && (32'(prow) <= 32'(MAX_DIM))
		&& (32'(pcol) <= 32'(MAX_DIM));
	assign nrows = NW'(held_rows_q) * NW'(fac_rows_q);
	assign ncols = NW'(held_cols_q) * NW'(fac_cols_q);

	assign load_we = acc && (mode == MODE_ELEM) && !loading_q && !full_q
		&& (held_rows_q != '0) && (held_cols_q != '0);
	assign fac_we  = acc && (mode == MODE_ELEM) && loading_q && (fac_rows_q != '0)
		&& (fac_cols_q != '0);
	assign load_data = STAT_W'(value);

	// loads go to the current bank, product writes to the other one
	assign we0 = (load_we && !cur_q) || (v_s2 && cur_q);
	assign we1 = (load_we && cur_q) || (v_s2 && !cur_q);
	assign wa0 = load_we ? {lr_q, lc_q} : dst_s2;
	assign wa1 = wa0;
	assign wd0 = load_we ? load_data : prod_s2;
	assign wd1 = wd0;
	assign held_rd = cur_q ? rd1 : rd0;

	kcws_ram #(.WIDTH(STAT_W), .DEPTH(1 << HA)) u_bank0 (
		.clk(clk), .we(we0), .waddr(wa0), .wdata(wd0), .raddr({wi_q, wj_q}), .rdata(rd0)
	);
	kcws_ram #(.WIDTH(STAT_W), .DEPTH(1 << HA)) u_bank1 (
		.clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr({wi_q, wj_q}), .rdata(rd1)
	);
	kcws_ram #(.WIDTH(VALUE_W), .DEPTH(1 << FA)) u_factor (
		.clk(clk), .we(fac_we), .waddr({fr_q, fc_q}), .wdata(value), .raddr({wk_q, wl_q}),
		.rdata(fac_rd)
	);
	kcws_ram #(.WIDTH(STAT_W), .DEPTH(1 << DW)) u_colsum (
		.clk(clk), .we(col_we), .waddr(cj_s1), .wdata(cs), .raddr(wj_q), .rdata(col_rd)
	);

	assign prod_full = $signed(held_rd) * $signed(fac_rd);
	assign x = $signed(held_rd);
	assign rs = j0_s1 ? x : rsum_q + x;
	// back-to-back hits on one column (single-column matrix) use the last write
	assign prev_col = (fwd_v_q && fwd_a_q == cj_s1) ? $signed(fwd_d_q) : $signed(col_rd);
	assign cs = i0_s1 ? x : prev_col + x;
	assign col_we = v_s1 && (state_q == ST_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= 1'b0;
			held_rows_q <= '0;
			held_cols_q <= '0;
			fac_rows_q  <= '0;
			fac_cols_q  <= '0;
			loading_q   <= 1'b0;
			err_q       <= 1'b0;
			full_q      <= 1'b0;
			lr_q        <= '0;
			lc_q        <= '0;
			fr_q        <= '0;
			fc_q        <= '0;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			fwd_v_q     <= 1'b0;
			kcnt_q      <= '0;
			wi_q        <= '0;
			wj_q        <= '0;
			wk_q        <= '0;
			wl_q        <= '0;
			rbase_q     <= '0;
			cbase_q     <= '0;
		end else begin
			v_s1 <= issue_q && (state_q == ST_APPLY || state_q == ST_ROWS
				|| state_q == ST_COLS);
			v_s2 <= v_s1 && (state_q == ST_APPLY);
			if (col_we)
				fwd_v_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (mode)
							MODE_BEGIN: begin
								loading_q <= 1'b0;
								full_q    <= 1'b0;
								lr_q      <= '0;
								lc_q      <= '0;
								err_q     <= !rows_ok0;
								held_rows_q <= rows_ok0 ? CW'(rows) : '0;
								held_cols_q <= rows_ok0 ? CW'(cols) : '0;
							end
							MODE_ELEM: begin
								if (load_we) begin
									if (lc_last) begin
										lc_q <= '0;
										if (lr_last)
											full_q <= 1'b1;
										else
											lr_q <= lr_q + DW'(1);
									end else begin
										lc_q <= lc_q + DW'(1);
									end
								end
								if (fac_we) begin
									if (fc_last) begin
										fc_q <= '0;
										if (fr_last) begin
											fr_q    <= '0;
											state_q <= ST_APPLY;
											wi_q    <= '0;
											wj_q    <= '0;
											wk_q    <= '0;
											wl_q    <= '0;
											rbase_q <= '0;
											cbase_q <= '0;
											issue_q <= (held_rows_q != '0);
										end else begin
											fr_q <= fr_q + FW'(1);
										end
									end else begin
										fc_q <= fc_q + FW'(1);
									end
								end
							end
							MODE_FACTOR: begin
								loading_q  <= 1'b1;
								fr_q       <= '0;
								fc_q       <= '0;
								fac_rows_q <= rows_ok2 ? FCW'(rows) : '0;
								fac_cols_q <= rows_ok2 ? FCW'(cols) : '0;
								if (!rows_ok2)
									err_q <= 1'b1;
							end
							MODE_REPORT: begin
								state_q <= ST_ROWS;
								wi_q    <= '0;
								wj_q    <= '0;
								issue_q <= (held_rows_q != '0);
								fwd_v_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_APPLY: begin
					if (issue_q) begin
						if (wl_last) begin
							wl_q <= '0;
							if (wk_last) begin
								wk_q <= '0;
								if (wj_last) begin
									wj_q    <= '0;
									cbase_q <= '0;
									if (wi_last)
										issue_q <= 1'b0;
									else begin
										wi_q    <= wi_q + DW'(1);
										rbase_q <= rbase_q + DW'(fac_rows_q);
									end
								end else begin
									wj_q    <= wj_q + DW'(1);
									cbase_q <= cbase_q + DW'(fac_cols_q);
								end
							end else begin
								wk_q <= wk_q + FW'(1);
							end
						end else begin
							wl_q <= wl_q + FW'(1);
						end
					end else if (!v_s1 && !v_s2) begin
						cur_q       <= !cur_q;
						held_rows_q <= CW'(nrows);
						held_cols_q <= CW'(ncols);
						fac_rows_q  <= '0;
						fac_cols_q  <= '0;
						wi_q        <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_ROWS: begin
					if (issue_q) begin
						if (wj_last) begin
							wj_q <= '0;
							if (wi_last)
								issue_q <= 1'b0;
							else
								wi_q <= wi_q + DW'(1);
						end else begin
							wj_q <= wj_q + DW'(1);
						end
					end else if (!v_s1) begin
						state_q <= ST_COLS;
						wi_q    <= '0;
						wj_q    <= '0;
						issue_q <= (held_cols_q != '0);
					end
				end
				ST_COLS: begin
					if (issue_q) begin
						if (wj_last) begin
							wj_q    <= '0;
							issue_q <= 1'b0;
						end else begin
							wj_q <= wj_q + DW'(1);
						end
					end else if (!v_s1) begin
						state_q <= ST_EMIT;
						kcnt_q  <= '0;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (kcnt_q == STAT_MIN_COL) begin
							kcnt_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							kcnt_q <= kcnt_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk pipeline payload
	always_ff @(posedge clk) begin
		dst_s1  <= {DW'(rbase_q + DW'(wk_q)), DW'(cbase_q + DW'(wl_q))};
		fst_s1  <= (wi_q == '0) && (wj_q == '0);
		i0_s1   <= (wi_q == '0);
		j0_s1   <= (wj_q == '0);
		rend_s1 <= wj_last;
		cj_s1   <= wj_q;
		dst_s2  <= dst_s1;
		prod_s2 <= prod_full[STAT_W-1:0];
		if (acc && mode == MODE_REPORT) begin
			emax_q <= -EMPTY_BOUND;
			emin_q <= EMPTY_BOUND;
			rmax_q <= -EMPTY_BOUND;
			rmin_q <= EMPTY_BOUND;
			cmax_q <= -EMPTY_BOUND;
			cmin_q <= EMPTY_BOUND;
		end
		if (v_s1 && state_q == ST_ROWS) begin
			if (fst_s1 || x > emax_q)
				emax_q <= x;
			if (fst_s1 || x < emin_q)
				emin_q <= x;
			rsum_q <= rs;
			if (rend_s1) begin
				if (i0_s1 || rs > rmax_q)
					rmax_q <= rs;
				if (i0_s1 || rs < rmin_q)
					rmin_q <= rs;
			end
			fwd_a_q <= cj_s1;
			fwd_d_q <= cs;
		end
		if (v_s1 && state_q == ST_COLS) begin
			if (j0_s1 || $signed(col_rd) > cmax_q)
				cmax_q <= $signed(col_rd);
			if (j0_s1 || $signed(col_rd) < cmin_q)
				cmin_q <= $signed(col_rd);
		end
	end

	assign out_valid  = (state_q == ST_EMIT);
	assign stat_kind  = kcnt_q;
	assign size_error = err_q;
	assign last       = (kcnt_q == STAT_MIN_COL);

	always_comb begin
		case (kcnt_q)
			STAT_MAX_ELEM: stat_value = emax_q;
			STAT_MIN_ELEM: stat_value = emin_q;
			STAT_MAX_ROW:  stat_value = rmax_q;
			STAT_MIN_ROW:  stat_value = rmin_q;
			STAT_MAX_COL:  stat_value = cmax_q;
			default:       stat_value = cmin_q;
		endcase
	end

	`ASSERT_PROP(a_report_leaves_idle, clk, arst_n, (acc && mode == MODE_REPORT) |=> !in_ready)
	`ASSERT_PROP(a_last_beat_ends, clk, arst_n, (out_valid && out_ready && last) |=> !out_valid)
	`ASSERT_NEVER(a_write_clash, clk, arst_n, load_we && v_s2)
	`ASSERT_NEVER(a_kind_range, clk, arst_n, out_valid && kcnt_q > STAT_MIN_COL)
endmodule

// ----- test/tb_kronecker_chain_with_stats_core.sv -----
// Testbench for kronecker_chain_with_stats_core: directed and random chains checked against a predictor.
module tb_kronecker_chain_with_stats_core;
	import kcws_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HELD_DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;
	localparam int FAC_DEPTH = MAX_FACTOR_DIM_DEF * MAX_FACTOR_DIM_DEF;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int TAIL_CYCLES = 5000;

	typedef struct packed {
		kind_t kind;
		logic [STAT_W-1:0] val;
		logic err;
		logic lst;
	} stat_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = MODE_BEGIN;
	logic [DIM_W-1:0] rows = '0;
	logic [DIM_W-1:0] cols = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KIND_W-1:0] stat_kind;
	logic signed [STAT_W-1:0] stat_value;
	logic size_error;
	logic last;

	kronecker_chain_with_stats_core dut (.*);

	always #2 clk = ~clk;

	// predictor state
	logic [31:0] held_mem [HELD_DEPTH];
	logic [31:0] prod_mem [HELD_DEPTH];
	logic [15:0] fac_mem [FAC_DEPTH];
	int unsigned hold_r, hold_c, fac_r, fac_c, fill_cnt;
	bit in_factor, err_flag;

	stat_beat_t stats_pending [$];
	int mismatches = 0;
	longint cycles = 0;
	int sent = 0;
	int burst_left = 0;
	bit no_gaps = 0;

	function automatic logic [31:0] sext16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic void fold_factor();
		int unsigned nr, nc, idx;
		nr = hold_r * fac_r;
		nc = hold_c * fac_c;
		for (int unsigned i = 0; i < hold_r; i++)
			for (int unsigned j = 0; j < hold_c; j++)
				for (int unsigned k = 0; k < fac_r; k++)
					for (int unsigned l = 0; l < fac_c; l++) begin
						idx = (i * fac_r + k) * nc + j * fac_c + l;
						if (idx < HELD_DEPTH)
							prod_mem[idx] = held_mem[i * hold_c + j] *
								sext16(fac_mem[k * fac_c + l]);
					end
		if (nr * nc <= HELD_DEPTH)
			for (int unsigned n = 0; n < nr * nc; n++) held_mem[n] = prod_mem[n];
		hold_r = nr;
		hold_c = nc;
	endfunction

	function automatic void push_stat(kind_t k, longint v);
		stat_beat_t b;
		b.kind = k;
		b.val = v[31:0];
		b.err = err_flag;
		b.lst = (k == STAT_MIN_COL);
		stats_pending.push_back(b);
	endfunction

	function automatic void predict_stats();
		longint emax, emin, rmax, rmin, cmax, cmin, s;
		logic [31:0] sum;
		bit have_e;
		emax = -2000000000; emin = 2000000000;
		rmax = -2000000000; rmin = 2000000000;
		cmax = -2000000000; cmin = 2000000000;
		have_e = 0;
		for (int unsigned i = 0; i < hold_r; i++) begin
			sum = '0;
			for (int unsigned j = 0; j < hold_c; j++) begin
				s = longint'($signed(held_mem[i * hold_c + j]));
				if (!have_e || s > emax) emax = s;
				if (!have_e || s < emin) emin = s;
				have_e = 1;
				sum += held_mem[i * hold_c + j];
			end
			s = longint'($signed(sum));
			if (i == 0 || s > rmax) rmax = s;
			if (i == 0 || s < rmin) rmin = s;
		end
		for (int unsigned j = 0; j < hold_c; j++) begin
			sum = '0;
			for (int unsigned i = 0; i < hold_r; i++) sum += held_mem[i * hold_c + j];
			s = longint'($signed(sum));
			if (j == 0 || s > cmax) cmax = s;
			if (j == 0 || s < cmin) cmin = s;
		end
		push_stat(STAT_MAX_ELEM, emax);
		push_stat(STAT_MIN_ELEM, emin);
		push_stat(STAT_MAX_ROW, rmax);
		push_stat(STAT_MIN_ROW, rmin);
		push_stat(STAT_MAX_COL, cmax);
		push_stat(STAT_MIN_COL, cmin);
	endfunction

	function automatic void predict_beat(mode_t m, int unsigned r, int unsigned c,
			logic [15:0] v);
		case (m)
			MODE_BEGIN: begin
				in_factor = 0;
				fill_cnt = 0;
				err_flag = 0;
				if (r >= 1 && r <= MAX_DIM_DEF && c >= 1 && c <= MAX_DIM_DEF) begin
					hold_r = r;
					hold_c = c;
				end else begin
					hold_r = 0;
					hold_c = 0;
					err_flag = 1;
				end
			end
			MODE_ELEM: begin
				if (!in_factor) begin
					if (fill_cnt < hold_r * hold_c && fill_cnt < HELD_DEPTH) begin
						held_mem[fill_cnt] = sext16(v);
						fill_cnt++;
					end
				end else if (fill_cnt < fac_r * fac_c && fill_cnt < FAC_DEPTH) begin
					fac_mem[fill_cnt] = v;
					fill_cnt++;
					if (fill_cnt == fac_r * fac_c) begin
						fold_factor();
						fac_r = 0;
						fac_c = 0;
						fill_cnt = 0;
					end
				end
			end
			MODE_FACTOR: begin
				in_factor = 1;
				fill_cnt = 0;
				if (r >= 1 && r <= MAX_FACTOR_DIM_DEF && c >= 1 && c <= MAX_FACTOR_DIM_DEF
						&& hold_r * r <= MAX_DIM_DEF && hold_c * c <= MAX_DIM_DEF) begin
					fac_r = r;
					fac_c = c;
				end else begin
					fac_r = 0;
					fac_c = 0;
					err_flag = 1;
				end
			end
			default: predict_stats();
		endcase
	endfunction

	// one input beat; called at a falling edge, returns at a falling edge
	task automatic send_item(mode_t m, int unsigned r, int unsigned c, logic [15:0] v);
		int gap;
		gap = 0;
		if (!no_gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		rows <= r[DIM_W-1:0];
		cols <= c[DIM_W-1:0];
		value <= v;
		do @(posedge clk); while (!in_ready);
		predict_beat(m, r, c, v);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_elems(int n);
		for (int i = 0; i < n; i++) send_item(MODE_ELEM, $urandom, $urandom, $urandom);
	endtask

	// begin a matrix and fill it completely, so no unwritten entry is ever read
	task automatic load_matrix(int unsigned r, int unsigned c);
		send_item(MODE_BEGIN, r, c, $urandom);
		if (r >= 1 && r <= 64 && c >= 1 && c <= 64) send_elems(r * c);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (stats_pending.size() != 0) @(negedge clk);
		// a product walk may still run without producing any beat
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic test_directed();
		send_item(MODE_BEGIN, 2, 3, '0);
		send_item(MODE_ELEM, 0, 0, 16'h7fff);
		send_item(MODE_ELEM, 0, 0, 16'h8000);
		send_item(MODE_ELEM, 0, 0, 16'h0000);
		send_item(MODE_ELEM, 0, 0, 16'h0001);
		send_item(MODE_ELEM, 0, 0, 16'hffff);
		send_item(MODE_ELEM, 0, 0, 16'h0005);
		send_item(MODE_ELEM, 0, 0, 16'h1234);   // surplus element
		send_item(MODE_REPORT, 0, 0, '0);
		send_item(MODE_FACTOR, 2, 2, '0);
		send_item(MODE_ELEM, 0, 0, 16'h8000);
		send_item(MODE_ELEM, 0, 0, 16'h7fff);
		send_item(MODE_ELEM, 0, 0, 16'hffff);
		send_item(MODE_ELEM, 0, 0, 16'h8000);
		send_item(MODE_ELEM, 0, 0, 16'h4321);   // after factor applied
		send_item(MODE_REPORT, 0, 0, '0);
		send_item(MODE_FACTOR, 17, 1, '0);      // too large, dropped
		send_item(MODE_ELEM, 0, 0, 16'h0003);
		send_item(MODE_REPORT, 0, 0, '0);
		send_item(MODE_BEGIN, 0, 127, '0);      // empty matrix
		send_item(MODE_REPORT, 0, 0, '0);
		send_item(MODE_BEGIN, 65, 1, '0);
		send_item(MODE_FACTOR, 1, 0, '0);
		send_item(MODE_REPORT, 0, 0, '0);
	endtask

	task automatic test_largest_matrix();
		load_matrix(4, 4);
		// 4x4 -> 64x4 -> 64x64, each factor at the largest dimension
		send_item(MODE_FACTOR, 16, 1, '0);
		send_elems(16);
		send_item(MODE_FACTOR, 1, 16, '0);
		send_elems(16);
		send_item(MODE_REPORT, 0, 0, '0);
		send_item(MODE_FACTOR, 2, 1, '0);       // exceeds the store
		send_elems(2);
		send_item(MODE_FACTOR, 1, 1, '0);
		send_item(MODE_ELEM, 0, 0, 16'hffff);
		send_item(MODE_REPORT, 0, 0, '0);
	endtask

	task automatic test_incomplete_factor();
		load_matrix(1, 1);
		send_item(MODE_FACTOR, 2, 2, '0);
		send_elems(3);
		send_item(MODE_REPORT, 0, 0, '0);
		send_item(MODE_FACTOR, 1, 2, '0);
		send_elems(2);
		send_item(MODE_REPORT, 0, 0, '0);
	endtask

	task automatic test_random_chains();
		int start, nf, sel;
		int unsigned r, c;
		start = sent;
		while (sent - start < 230) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				// noise: bad begin (empty matrix), stray elements, report
				send_item(MODE_BEGIN, $urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
					$urandom_range(0, 127), $urandom);
				send_elems($urandom_range(0, 3));
				send_item(MODE_REPORT, $urandom, $urandom, $urandom);
				continue;
			end
			r = (sel == 1) ? $urandom_range(1, 12) : $urandom_range(1, 4);
			c = (sel == 1) ? $urandom_range(1, 12) : $urandom_range(1, 4);
			load_matrix(r, c);
			if ($urandom_range(0, 1)) send_item(MODE_REPORT, $urandom, $urandom, $urandom);
			nf = $urandom_range(0, 3);
			for (int f = 0; f < nf; f++) begin
				if ($urandom_range(0, 5) == 0) begin
					r = $urandom_range(0, 127);
					c = $urandom_range(0, 127);
				end else begin
					r = $urandom_range(1, 3);
					c = $urandom_range(1, 3);
				end
				send_item(MODE_FACTOR, r, c, $urandom);
				case ($urandom_range(0, 4))
					0: send_elems($urandom_range(0, 3));         // likely incomplete
					1: send_elems((r * c > 16 ? 3 : r * c) + 2); // with surplus
					default: send_elems(r * c > 16 ? 3 : r * c);
				endcase
				if ($urandom_range(0, 2) == 0)
					send_item(MODE_REPORT, $urandom, $urandom, $urandom);
			end
			send_item(MODE_REPORT, $urandom, $urandom, $urandom);
		end
		no_gaps = 0;
	endtask

	// receiver stall pattern
	int stall_phase = 0;
	int phase_left = 0;
	always @(negedge clk) begin
		if (phase_left == 0) begin
			stall_phase = $urandom_range(0, 3);
			phase_left = $urandom_range(20, 300);
		end
		phase_left--;
		case (stall_phase)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((phase_left % 8) < 5);
		endcase
	end

	always @(posedge clk) begin
		stat_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (stats_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat kind=%0d value=%0d", stat_kind, stat_value);
			end else begin
				want = stats_pending.pop_front();
				if (stat_kind !== want.kind || stat_value !== want.val ||
						size_error !== want.err || last !== want.lst) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind=%0d value=%0d err=%0b last=%0b, got kind=%0d value=%0d err=%0b last=%0b",
							want.kind, $signed(want.val), want.err, want.lst,
							stat_kind, stat_value, size_error, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		hold_r = 0; hold_c = 0; fac_r = 0; fac_c = 0; fill_cnt = 0;
		in_factor = 0; err_flag = 0;
		for (int n = 0; n < HELD_DEPTH; n++) begin
			held_mem[n] = '0;
			prod_mem[n] = '0;
		end
		for (int n = 0; n < FAC_DEPTH; n++) fac_mem[n] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		wait_drained();
		test_largest_matrix();
		test_incomplete_factor();
		wait_drained();
		test_random_chains();
		wait_drained();
		if (mismatches == 0 && stats_pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
